// ----- rtl/pls_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pls_pkg;

  localparam int unsigned CoordW = 32;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } point_t;

  typedef struct packed {
    logic ins;
    logic shift_up;
  } cell_ctl_t;

  // true if point a is emitted before point b
  function automatic logic goes_before(input point_t a, input point_t b);
    logic res;
    if (a.x != b.x) begin
      res = $signed(a.x) > $signed(b.x);
    end else begin
      res = $signed(a.y) > $signed(b.y);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/point_sort_lexicographic_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// insertion chain of MAX_POINTS compare cells, sorted descending by x then y
// throughput: one point word per cycle while collecting, one result word per cycle draining while out_stall is low
// latency: first result word is offered the cycle after the last point is taken
// a set drains until its last stored point is taken; no input word is taken while draining
// reset (rst_n low, synchronous) empties the chain and clears the drop flag

module point_sort_lexicographic_top #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_coord_x,
  input  wire logic [31:0] in_coord_y,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_x,
  output logic [31:0]      out_y,
  output logic             out_last,
  output logic             out_overflowed
);

  pls_pkg::point_t   pt_w    [MAX_POINTS];
  logic              valid_w [MAX_POINTS];
  logic              before_w[MAX_POINTS];
  pls_pkg::point_t   new_pt;
  pls_pkg::cell_ctl_t ctl;

  logic draining_r, draining_nxt;
  logic drop_r, drop_nxt;
  logic in_acc, out_acc, full, run_end;

  assign new_pt.x = in_coord_x;
  assign new_pt.y = in_coord_y;

  assign in_stall  = draining_r;
  assign in_acc    = in_valid && !draining_r;
  assign full      = valid_w[MAX_POINTS-1];
  assign out_valid = draining_r;
  assign out_acc   = draining_r && !out_stall;
  assign run_end   = out_acc && !valid_w[1];

  assign ctl.ins      = in_acc && !full;
  assign ctl.shift_up = out_acc;

  generate
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      pls_pkg::point_t prev_pt, next_pt;
      logic            prev_valid, prev_before, next_valid;
      if (i == 0) begin : g_head
        assign prev_pt     = '0;
        assign prev_valid  = 1'b0;
        assign prev_before = 1'b0;
      end else begin : g_mid
        assign prev_pt     = pt_w[i-1];
        assign prev_valid  = valid_w[i-1];
        assign prev_before = before_w[i-1];
      end
      if (i == MAX_POINTS - 1) begin : g_tail
        assign next_pt    = '0;
        assign next_valid = 1'b0;
      end else begin : g_body
        assign next_pt    = pt_w[i+1];
        assign next_valid = valid_w[i+1];
      end
      pls_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .new_pt     (new_pt),
        .prev_pt    (prev_pt),
        .prev_valid (prev_valid),
        .prev_before(prev_before),
        .next_pt    (next_pt),
        .next_valid (next_valid),
        .pt         (pt_w[i]),
        .valid      (valid_w[i]),
        .ahead      (before_w[i])
      );
    end
  endgenerate

  always_comb begin
    draining_nxt = draining_r;
    drop_nxt     = drop_r;
    if (in_acc && in_last) begin
      draining_nxt = 1'b1;
    end else if (run_end) begin
      draining_nxt = 1'b0;
    end
    if (in_acc && full) begin
      drop_nxt = 1'b1;
    end else if (run_end) begin
      drop_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r <= 1'b0;
      drop_r     <= 1'b0;
    end else begin
      draining_r <= draining_nxt;
      drop_r     <= drop_nxt;
    end
  end

  assign out_x          = pt_w[0].x;
  assign out_y          = pt_w[0].y;
  assign out_last       = !valid_w[1];
  assign out_overflowed = drop_r;

endmodule

`default_nettype wire

// ----- rtl/pls_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pls_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pls_pkg::cell_ctl_t ctl,
  input  wire pls_pkg::point_t   new_pt,
  input  wire pls_pkg::point_t   prev_pt,
  input  wire logic              prev_valid,
  input  wire logic              prev_before,
  input  wire pls_pkg::point_t   next_pt,
  input  wire logic              next_valid,
  output pls_pkg::point_t        pt,
  output logic                   valid,
  output logic                   ahead
);

  pls_pkg::point_t pt_r, pt_nxt;
  logic            valid_r, valid_nxt;

  assign ahead  = !valid_r || pls_pkg::goes_before(new_pt, pt_r);
  assign pt     = pt_r;
  assign valid  = valid_r;

  always_comb begin
    pt_nxt    = pt_r;
    valid_nxt = valid_r;
    if (ctl.shift_up) begin
      pt_nxt    = next_pt;
      valid_nxt = next_valid;
    end else if (ctl.ins && ahead) begin
      if (prev_before) begin
        pt_nxt    = prev_pt;
        valid_nxt = prev_valid;
      end else begin
        pt_nxt    = new_pt;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pt_r <= pt_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- bench/sorted_run_checker.sv -----
`timescale 1ns / 1ps

module sorted_run_checker #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [31:0] in_coord_x,
  input  wire logic [31:0] in_coord_y,
  input  wire logic        in_last,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] out_x,
  input  wire logic [31:0] out_y,
  input  wire logic        out_last,
  input  wire logic        out_overflowed,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    pls_pkg::point_t pt;
    logic            last;
    logic            ovf;
  } run_word_t;

  pls_pkg::point_t held_q[$];
  logic            drop_seen = 1'b0;
  run_word_t       expected_run_q[$];
  int              fails = 0;

  // offset-binary key: unsigned compare gives signed x then signed y order
  function automatic logic [63:0] order_key(input pls_pkg::point_t p);
    return {~p.x[31], p.x[30:0], ~p.y[31], p.y[30:0]};
  endfunction

  task automatic take_point();
    pls_pkg::point_t p;
    pls_pkg::point_t ranked[$];
    run_word_t       w;
    int              j;
    p.x = in_coord_x;
    p.y = in_coord_y;
    if (held_q.size() < MAX_POINTS) begin
      held_q.push_back(p);
    end else begin
      drop_seen = 1'b1;
    end
    if (in_last) begin
      foreach (held_q[i]) begin
        j = ranked.size();
        while (j > 0 && order_key(held_q[i]) > order_key(ranked[j-1])) begin
          j--;
        end
        ranked.insert(j, held_q[i]);
      end
      foreach (ranked[i]) begin
        w.pt   = ranked[i];
        w.last = (i == ranked.size() - 1);
        w.ovf  = drop_seen;
        expected_run_q.push_back(w);
      end
      held_q.delete();
      drop_seen = 1'b0;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: out_%s expected %h got %h", $time, name, want, got);
      fails++;
    end
  endtask

  task automatic check_word();
    run_word_t w;
    if (expected_run_q.size() == 0) begin
      $display("%0t: unexpected word expected none got x=%h y=%h last=%b ovf=%b",
               $time, out_x, out_y, out_last, out_overflowed);
      fails++;
    end else begin
      w = expected_run_q.pop_front();
      compare_field("x", w.pt.x, out_x);
      compare_field("y", w.pt.y, out_y);
      compare_field("last", 32'(w.last), 32'(out_last));
      compare_field("overflowed", 32'(w.ovf), 32'(out_overflowed));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_q.delete();
      drop_seen = 1'b0;
      expected_run_q.delete();
    end else begin
      if (in_valid && !in_stall) take_point();
      if (out_valid && !out_stall) check_word();
    end
    pending    <= expected_run_q.size();
    fail_count <= fails;
  end

endmodule

// ----- bench/point_sort_lexicographic_top_tb.sv -----
`timescale 1ns / 1ps

module point_sort_lexicographic_top_tb;

  localparam int unsigned MaxPoints  = 16;
  localparam int          CycleLimit = 200000;
  localparam int          ItemTarget = 350;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_coord_x = '0;
  logic [31:0] in_coord_y = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic        out_last;
  logic        out_overflowed;

  int fail_count;
  int pending;
  int idle_pct = 30;
  int stall_pct = 87;
  int items_sent = 0;
  int cycle_count = 0;

  point_sort_lexicographic_top #(
    .MAX_POINTS(MaxPoints)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_last      (out_last),
    .out_overflowed(out_overflowed)
  );

  sorted_run_checker #(
    .MAX_POINTS(MaxPoints)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_last      (out_last),
    .out_overflowed(out_overflowed),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("point_sort_lexicographic_top regression: fail");
      $finish;
    end
  end

  function automatic logic [31:0] pick_coord();
    int unsigned kind;
    kind = $urandom_range(9);
    if (kind <= 4) begin
      return $urandom;
    end else if (kind <= 7) begin
      // small pool so that keys collide
      return (32'($urandom_range(6)) - 32'd3) << 16;
    end else begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
  endfunction

  task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                            input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    in_last    <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  initial begin
    int          set_size;
    logic [31:0] x;
    logic [31:0] y;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single point set
    send_point(32'h8000_0000, 32'h7fff_ffff, 1'b1);
    // extremes, x ties and duplicate points
    send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'hffff_ffff, 32'h0000_0001, 1'b0);
    send_point(32'h8000_0000, 32'hffff_ffff, 1'b1);
    // store full, dropped points
    for (int i = 0; i < 18; i++) begin
      send_point(32'(i) * 32'h0001_0000 ^ 32'h8000_5555, 32'hffff_0000 - 32'(i),
                 i == 17);
    end

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        idle_pct  = 87;
        stall_pct = 30;
      end else if (phase == 2) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      while (items_sent < 25 + (phase + 1) * (ItemTarget / 3)) begin
        if ($urandom_range(99) < 85) begin
          set_size = $urandom_range(1, MaxPoints);
        end else begin
          set_size = $urandom_range(MaxPoints + 1, MaxPoints + 6);
        end
        x = pick_coord();
        for (int i = 0; i < set_size; i++) begin
          if ($urandom_range(99) >= 20) x = pick_coord();
          y = pick_coord();
          send_point(x, y, i == set_size - 1);
        end
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("point_sort_lexicographic_top regression: pass");
    end else begin
      $display("point_sort_lexicographic_top regression: fail");
    end
    $finish;
  end

endmodule
